// ----- hdl/gld_pkg.sv -----
package gld_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 1024;

    // fixed field widths
    localparam int SAMPLE_BITS = 4;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 7;
    localparam int RISK_W      = 22;

    // configuration port
    localparam int GRID_COLS_W = 8;
    localparam int GRID_ROWS_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int GRID_RESET  = 100;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

    // decisions one sample can release, and result queue depth
    localparam int RUN_MAX  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample upper;   // two rows above the incoming sample
        t_sample centre;  // row above the incoming sample
    } t_entry;

    // neighborhood of the incoming sample, taken from the line buffer
    typedef struct packed {
        t_sample up;       // row r-2, column c
        t_sample self;     // row r-1, column c
        t_sample right;    // row r-1, column c+1
        t_sample left_up;  // row r-1, column c-1
        t_sample p1;       // row r, column c-1
        t_sample p2;       // row r, column c-2
    } t_window;

    typedef struct packed {
        t_sample          v;
        t_window          win;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] row_up;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_left;
        logic             r_ge1;
        logic             r_ge2;
        logic             c_ge1;
        logic             c_ge2;
        logic             has_right;
        logic             last_row;
        logic             last_col;
    } t_stage;

    typedef struct packed {
        logic [ROW_W-1:0]  pixel_row;
        logic [COL_W-1:0]  pixel_column;
        t_sample           pixel_value;
        logic              is_minimum;
        logic [RISK_W-1:0] risk_total;
        logic              last_in_run;
        logic              frame_done;
    } t_word;

    typedef t_word [RUN_MAX-1:0] t_run_words;

    function automatic logic [RISK_W-1:0] risk_add(input logic [RISK_W-1:0] acc,
                                                   input t_sample v);
        logic [RISK_W:0] sum;
        sum = {1'b0, acc} + (RISK_W+1)'(v) + (RISK_W+1)'(1);
        return sum[RISK_W] ? {RISK_W{1'b1}} : sum[RISK_W-1:0];
    endfunction

endpackage

// ----- hdl/gld_in_if.sv -----
interface gld_in_if import gld_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_height;

    modport source (output valid, output sample_height, input ready);
    modport sink   (input valid, input sample_height, output ready);
endinterface

// ----- hdl/gld_out_if.sv -----
interface gld_out_if import gld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  pixel_row;
    logic [COL_W-1:0]  pixel_column;
    t_sample           pixel_value;
    logic              is_minimum;
    logic [RISK_W-1:0] risk_total;
    logic              last_in_run;
    logic              frame_done;

    modport source (output valid, output pixel_row, output pixel_column, output pixel_value,
                    output is_minimum, output risk_total, output last_in_run,
                    output frame_done, input ready);
    modport sink   (input valid, input pixel_row, input pixel_column, input pixel_value,
                    input is_minimum, input risk_total, input last_in_run,
                    input frame_done, output ready);
endinterface

// ----- hdl/grid_local_minimum_detector.sv -----
// channel    dir  word                                  handshake
// i_sample   in   sample_height                         valid/ready
// o_result   out  pixel_row, pixel_column, pixel_value, valid/ready
//                 is_minimum, risk_total, last_in_run,
//                 frame_done
// One sample is taken per cycle while the queue has room; words pass the stage
// register and a four-word result queue. Rows above the last release at most
// one word per sample; the last row up to two (three on the final pixel), so
// there the single output port sets the pace: one word per cycle while ready.
// Reset is synchronous; the line memory is not cleared; the grid resets to 100x100.
// A stalled output holds its word; the input stalls once the queue cannot
// take a full run of three words behind the decision stage.
module grid_local_minimum_detector import gld_pkg::*; #(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gld_in_if.sink                i_sample,
    gld_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_CW = $clog2(MAX_COLUMNS);
    localparam int ROW_CW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [GRID_COLS_W-1:0] r_grid_columns;
    logic [GRID_ROWS_W-1:0] r_grid_rows;
    logic [COL_CW-1:0]      r_col;
    logic [ROW_CW-1:0]      r_row;
    logic [COL_CW-1:0]      n_col;
    logic [ROW_CW-1:0]      n_row;
    t_stage                 r_stage;
    logic                   r_stage_valid;
    t_stage                 n_stage;

    logic [COL_CW-1:0]      w_last_col;
    logic [ROW_CW-1:0]      w_last_row;
    logic                   w_accept;
    logic                   w_move;
    logic                   w_pop;
    logic [COL_CW-1:0]      w_buf_next_col;
    t_window                w_window;
    t_run_words             w_words;
    logic [RUN_MAX-1:0]     w_valid;
    logic [Q_CNT_W-1:0]     w_free;
    t_word                  w_head;

    // grid size in use: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (32'(r_grid_columns) > MAX_COLUMNS) begin
            w_last_col = COL_CW'(MAX_COLUMNS - 1);
        end else if (r_grid_columns == '0) begin
            w_last_col = '0;
        end else begin
            w_last_col = COL_CW'(32'(r_grid_columns) - 1);
        end
        if (32'(r_grid_rows) > MAX_ROWS) begin
            w_last_row = ROW_CW'(MAX_ROWS - 1);
        end else if (r_grid_rows == '0) begin
            w_last_row = '0;
        end else begin
            w_last_row = ROW_CW'(32'(r_grid_rows) - 1);
        end
    end

    assign w_move         = r_stage_valid && (w_free >= Q_CNT_W'(RUN_MAX));
    assign i_sample.ready = !r_stage_valid || w_move;
    assign w_accept       = i_sample.valid && i_sample.ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (r_col == w_last_col) begin
                n_col = '0;
                n_row = (r_row == w_last_row) ? '0 : r_row + ROW_CW'(1);
            end else begin
                n_col = r_col + COL_CW'(1);
            end
        end
    end

    assign w_buf_next_col = i_cfg_we ? '0 : n_col;

    gld_line_buf #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_accept   (w_accept),
        .i_sample   (i_sample.sample_height),
        .i_col      (r_col),
        .i_next_col (w_buf_next_col),
        .i_last_col (w_last_col),
        .o_window   (w_window)
    );

    always_comb begin
        n_stage.v         = i_sample.sample_height;
        n_stage.win       = w_window;
        n_stage.row       = ROW_W'(r_row);
        n_stage.row_up    = ROW_W'(r_row - ROW_CW'(1));
        n_stage.col       = COL_W'(r_col);
        n_stage.col_left  = COL_W'(r_col - COL_CW'(1));
        n_stage.r_ge1     = (r_row != '0);
        n_stage.r_ge2     = (32'(r_row) >= 2);
        n_stage.c_ge1     = (r_col != '0);
        n_stage.c_ge2     = (32'(r_col) >= 2);
        n_stage.has_right = (r_col != w_last_col);
        n_stage.last_row  = (r_row == w_last_row);
        n_stage.last_col  = (r_col == w_last_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GRID_COLS_W'(GRID_RESET);
            r_grid_rows    <= GRID_ROWS_W'(GRID_RESET);
            r_col          <= '0;
            r_row          <= '0;
            r_stage_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[GRID_COLS_W-1:0];
                    REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[GRID_ROWS_W-1:0];
                    default:          r_grid_rows    <= r_grid_rows;
                endcase
                // any write restarts the frame
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_accept) begin
                r_stage_valid <= 1'b1;
            end else if (w_move) begin
                r_stage_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage <= n_stage;
        end
    end

    gld_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (r_stage),
        .i_valid  (r_stage_valid),
        .i_commit (w_move),
        .i_clear  (i_cfg_we),
        .o_words  (w_words),
        .o_valid  (w_valid)
    );

    assign w_pop = o_result.valid && o_result.ready;

    gld_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_move),
        .i_words (w_words),
        .i_valid (w_valid),
        .i_pop   (w_pop),
        .o_free  (w_free),
        .o_valid (o_result.valid),
        .o_head  (w_head)
    );

    assign o_result.pixel_row    = w_head.pixel_row;
    assign o_result.pixel_column = w_head.pixel_column;
    assign o_result.pixel_value  = w_head.pixel_value;
    assign o_result.is_minimum   = w_head.is_minimum;
    assign o_result.risk_total   = w_head.risk_total;
    assign o_result.last_in_run  = w_head.last_in_run;
    assign o_result.frame_done   = w_head.frame_done;

endmodule

// ----- hdl/gld_line_buf.sv -----
module gld_line_buf import gld_pkg::*; #(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    localparam int COL_CW = $clog2(MAX_COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_accept,
    input  t_sample           i_sample,
    input  logic [COL_CW-1:0] i_col,
    input  logic [COL_CW-1:0] i_next_col,
    input  logic [COL_CW-1:0] i_last_col,
    output t_window           o_window
);

    t_entry            r_mem [MAX_COLUMNS];
    t_entry            r_rdata;
    t_entry            r_byp_data;
    logic              r_byp;
    t_entry            r_cur;
    t_sample           r_prev1;
    t_sample           r_p1;
    t_sample           r_p2;

    t_entry            w_wdata;
    t_entry            w_next;
    logic [COL_CW-1:0] w_raddr;

    // the upcoming sample's column entry sits in r_cur; the one after it is
    // prefetched every cycle so the right neighbor is ready at accept
    assign w_wdata = '{upper: r_cur.centre, centre: i_sample};
    assign w_raddr = (i_next_col == i_last_col) ? '0 : i_next_col + COL_CW'(1);
    assign w_next  = r_byp ? r_byp_data : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem[i_col] <= w_wdata;
        end
        r_rdata    <= r_mem[w_raddr];
        r_byp      <= i_accept && (w_raddr == i_col);
        r_byp_data <= w_wdata;
        if (i_accept) begin
            // single-column grid: the next sample reuses the entry just written
            r_cur   <= (i_next_col == i_col) ? w_wdata : w_next;
            r_prev1 <= r_cur.centre;
            r_p1    <= i_sample;
            r_p2    <= r_p1;
        end
    end

    assign o_window = '{up:      r_cur.upper,
                        self:    r_cur.centre,
                        right:   w_next.centre,
                        left_up: r_prev1,
                        p1:      r_p1,
                        p2:      r_p2};

endmodule

// ----- hdl/gld_decide.sv -----
module gld_decide import gld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage             i_stage,
    input  logic               i_valid,
    input  logic               i_commit,
    input  logic               i_clear,
    output t_run_words         o_words,
    output logic [RUN_MAX-1:0] o_valid
);

    logic [RISK_W-1:0]  r_acc;
    logic [RISK_W-1:0]  w_acc1;
    logic [RISK_W-1:0]  w_acc2;
    logic [RISK_W-1:0]  w_acc3;
    logic               w_m1;
    logic               w_m2;
    logic               w_m3;
    logic [RUN_MAX-1:0] w_valid;
    t_window            w_win;

    assign w_win = i_stage.win;

    // pixel above the sample
    assign w_m1 = (!i_stage.r_ge2     || (w_win.self < w_win.up))
               && (!i_stage.c_ge1     || (w_win.self < w_win.left_up))
               && (!i_stage.has_right || (w_win.self < w_win.right))
               && (w_win.self < i_stage.v);
    // last row: pixel left of the sample
    assign w_m2 = (!i_stage.r_ge1 || (w_win.p1 < w_win.left_up))
               && (!i_stage.c_ge2 || (w_win.p1 < w_win.p2))
               && (w_win.p1 < i_stage.v);
    // last pixel of the frame: the sample itself
    assign w_m3 = (!i_stage.r_ge1 || (i_stage.v < w_win.self))
               && (!i_stage.c_ge1 || (i_stage.v < w_win.p1));

    assign w_valid[0] = i_valid && i_stage.r_ge1;
    assign w_valid[1] = i_valid && i_stage.last_row && i_stage.c_ge1;
    assign w_valid[2] = i_valid && i_stage.last_row && i_stage.last_col;

    assign w_acc1 = (w_valid[0] && w_m1) ? risk_add(r_acc, w_win.self) : r_acc;
    assign w_acc2 = (w_valid[1] && w_m2) ? risk_add(w_acc1, w_win.p1) : w_acc1;
    assign w_acc3 = (w_valid[2] && w_m3) ? risk_add(w_acc2, i_stage.v) : w_acc2;

    always_comb begin
        o_words[0] = '{pixel_row: i_stage.row_up, pixel_column: i_stage.col,
                       pixel_value: w_win.self, is_minimum: w_m1, risk_total: w_acc1,
                       last_in_run: !w_valid[1] && !w_valid[2], frame_done: 1'b0};
        o_words[1] = '{pixel_row: i_stage.row, pixel_column: i_stage.col_left,
                       pixel_value: w_win.p1, is_minimum: w_m2, risk_total: w_acc2,
                       last_in_run: !w_valid[2], frame_done: 1'b0};
        o_words[2] = '{pixel_row: i_stage.row, pixel_column: i_stage.col,
                       pixel_value: i_stage.v, is_minimum: w_m3, risk_total: w_acc3,
                       last_in_run: 1'b1, frame_done: 1'b1};
    end

    assign o_valid = w_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
        end else if (i_commit) begin
            r_acc <= w_valid[2] ? '0 : w_acc3;
        end
    end

endmodule

// ----- hdl/gld_out_q.sv -----
module gld_out_q import gld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_run_words         i_words,
    input  logic [RUN_MAX-1:0] i_valid,
    input  logic               i_pop,
    output logic [Q_CNT_W-1:0] o_free,
    output logic               o_valid,
    output t_word              o_head
);

    t_word               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr;
    logic [Q_PTR_W-1:0]  r_rptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  w_off [RUN_MAX];
    logic [Q_CNT_W-1:0]  w_npush;

    // packed slot offset of each valid word
    always_comb begin
        w_off[0] = '0;
        for (int k = 1; k < RUN_MAX; k++) begin
            w_off[k] = w_off[k-1] + Q_PTR_W'(i_valid[k-1]);
        end
        w_npush = '0;
        if (i_push) begin
            for (int k = 0; k < RUN_MAX; k++) begin
                w_npush = w_npush + Q_CNT_W'(i_valid[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RUN_MAX; k++) begin
            if (i_push && i_valid[k]) begin
                r_q[r_wptr + w_off[k]] <= i_words[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + Q_PTR_W'(w_npush);
            r_rptr  <= r_rptr + Q_PTR_W'(i_pop);
            r_count <= r_count + w_npush - Q_CNT_W'(i_pop);
        end
    end

    assign o_free  = Q_CNT_W'(Q_DEPTH) - r_count;
    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rptr];

endmodule
